// ===== rtl/core/smd_pkg.sv =====
// Package for the squared Mahalanobis distance engine.
// Holds sizes, action codes, the back-end state type and saturation constants.
// No dependencies.
`default_nettype none
package smd_pkg;
  localparam int MAX_DIMS       = 8;
  localparam int MAX_COMPONENTS = 4;

  typedef enum logic [1:0] {
    ACT_LOC   = 2'd0,
    ACT_FAC   = 2'd1,
    ACT_POINT = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  localparam int unsigned CFG_DIMS  = 0;
  localparam int unsigned CFG_COMPS = 1;
  localparam logic [63:0] SAT64 = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_READ,
    BK_MAC,
    BK_DRAIN,
    BK_COLUMN,
    BK_EMIT
  } bk_state_t;
endpackage
`default_nettype wire

// ===== rtl/core/smd_if.sv =====
// Valid/ready channel interface for the distance engine.
// Payload fields are the input item and result item fields.
`default_nettype none
interface smd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [1:0]  component;
  logic [2:0]  row;
  logic [2:0]  col;
  logic signed [31:0] value;
  modport source (output valid, action, component, row, col, value, input ready);
  modport sink (input valid, action, component, row, col, value, output ready);
endinterface

interface smd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  comp_index;
  logic [63:0] distance;
  logic        last_of_run;
  modport source (output valid, comp_index, distance, last_of_run, input ready);
  modport sink (input valid, comp_index, distance, last_of_run, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/smd_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module smd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/core/smd_back.sv =====
// Back end: owns the stores and runs one shared multiply-accumulate over a
// point's triangular factor. Depends on smd_pkg and smd_ram.
`default_nettype none
module smd_back (
  input  wire logic        clk,
  input  wire logic        rst,
  // Command from the queue.
  input  wire logic        cmd_valid,
  output logic             cmd_ready,
  input  wire logic [1:0]  cmd_action,
  input  wire logic [1:0]  cmd_comp,
  input  wire logic [2:0]  cmd_row,
  input  wire logic [2:0]  cmd_col,
  input  wire logic [31:0] cmd_value,
  input  wire logic        cmd_fire,
  input  wire logic [6:0]  cmd_nd,
  input  wire logic [6:0]  cmd_nc,
  // Result register.
  output logic             res_valid,
  input  wire logic        res_ready,
  output logic [1:0]       res_comp,
  output logic [63:0]      res_dist,
  output logic             res_last
);
  import smd_pkg::*;

  localparam int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int CW = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
  localparam int LD = MAX_COMPONENTS * MAX_DIMS;
  localparam int FD = LD * MAX_DIMS;
  localparam int LAW = $clog2(LD) > 0 ? $clog2(LD) : 1;
  localparam int FAW = $clog2(FD) > 0 ? $clog2(FD) : 1;

  bk_state_t state, state_next;
  logic [DW-1:0] jj, mm;
  logic [CW-1:0] cc;
  logic [6:0] nd_r, nc_r;
  logic [31:0] point [MAX_DIMS];
  logic signed [80:0] acc;
  logic signed [32:0] diff;
  logic [31:0] fac_d;
  logic signed [65:0] prod;
  logic prod_v, df_v, rd_v;
  logic [63:0] total;
  logic sat;

  logic [CW-1:0] in_comp;
  logic [DW-1:0] in_row, in_col;
  logic in_ok;
  assign in_comp = cmd_comp[CW-1:0];
  assign in_row  = cmd_row[DW-1:0];
  assign in_col  = cmd_col[DW-1:0];
  assign in_ok = (32'(cmd_comp) < MAX_COMPONENTS) && (32'(cmd_row) < MAX_DIMS);

  // Store writes happen as commands are taken.
  logic take;
  assign cmd_ready = (state == BK_IDLE);
  assign take = cmd_valid && cmd_ready;

  logic loc_we, fac_we;
  logic [LAW-1:0] loc_wa, loc_ra;
  logic [FAW-1:0] fac_wa, fac_ra;
  logic [31:0] loc_rd, fac_rd;
  assign loc_we = take && cmd_action == ACT_LOC && in_ok;
  assign fac_we = take && cmd_action == ACT_FAC && in_ok && 32'(cmd_col) < MAX_DIMS;
  assign loc_wa = LAW'(32'(in_comp) * MAX_DIMS + 32'(in_row));
  assign fac_wa = FAW'((32'(in_comp) * MAX_DIMS + 32'(in_row)) * MAX_DIMS + 32'(in_col));
  assign loc_ra = LAW'(32'(cc) * MAX_DIMS + 32'(mm));
  assign fac_ra = FAW'((32'(cc) * MAX_DIMS + 32'(mm)) * MAX_DIMS + 32'(jj));

  smd_ram #(.WIDTH(32), .DEPTH(LD)) u_loc (
    .clk(clk), .we(loc_we), .waddr(loc_wa), .wdata(cmd_value),
    .raddr(loc_ra), .rdata(loc_rd));
  smd_ram #(.WIDTH(32), .DEPTH(FD)) u_fac (
    .clk(clk), .we(fac_we), .waddr(fac_wa), .wdata(cmd_value),
    .raddr(fac_ra), .rdata(fac_rd));

  // Point register file, written by coordinate commands.
  always_ff @(posedge clk) begin
    if (take && cmd_action == ACT_POINT && 32'(cmd_row) < MAX_DIMS) begin
      point[in_row] <= cmd_value;
    end
  end

  logic [DW-1:0] mm_d;
  logic issue, last_m;
  assign last_m = (mm == jj);

  // Column result: round magnitude, square, saturating add.
  logic signed [80:0] t_abs;
  logic [64:0] rnd;
  logic [31:0] r32;
  logic [63:0] sq;
  logic [64:0] sum;
  logic col_sat;
  always_comb begin
    t_abs = acc[80] ? -acc : acc;
    rnd = t_abs[64:0] + 65'h8000;
    r32 = rnd[47:16];
    sq = 64'(r32) * 64'(r32);
    sum = {1'b0, total} + {1'b0, sq};
    // Saturate when the magnitude, or its rounded value, reaches 2^16 in Q16.16 terms, or the 64-bit sum carries out.
    col_sat = (t_abs >= 81'sh1_0000_0000_0000) || rnd[48] || sum[64];
  end

  // Sequencer for components, columns and rows.
  always_comb begin
    state_next = state;
    issue = 1'b0;
    case (state)
      BK_IDLE:   if (take && cmd_action == ACT_POINT && cmd_fire) state_next = BK_READ;
      BK_READ:   begin issue = 1'b1; if (last_m) state_next = BK_DRAIN; end
      BK_DRAIN:  if (!rd_v && !df_v && !prod_v) state_next = BK_COLUMN;
      BK_COLUMN: state_next = (7'(jj) + 7'd1 == nd_r) ? BK_EMIT : BK_READ;
      BK_EMIT:   if (!res_valid || res_ready)
                   state_next = (7'(cc) + 7'd1 == nc_r) ? BK_IDLE : BK_READ;
      default:   state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      rd_v <= 1'b0;
      df_v <= 1'b0;
      prod_v <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      rd_v <= issue;
      df_v <= rd_v;
      prod_v <= df_v;
      if (state == BK_EMIT && (!res_valid || res_ready)) res_valid <= 1'b1;
      else if (res_ready) res_valid <= 1'b0;
    end
  end

  // Datapath: read, difference, multiply, accumulate.
  always_ff @(posedge clk) begin
    mm_d <= mm;
    diff <= 33'(signed'(point[mm_d])) - 33'(signed'(loc_rd));
    fac_d <= fac_rd;
    prod <= 66'(signed'(fac_d)) * 66'(diff);
    if (take) begin
      nd_r <= cmd_nd;
      nc_r <= cmd_nc;
      cc <= '0; jj <= '0; mm <= '0; acc <= '0; total <= '0; sat <= 1'b0;
    end
    if (issue && !last_m) mm <= mm + 1'b1;
    if (prod_v) acc <= acc + 81'(prod);
    if (state == BK_COLUMN) begin
      if (col_sat) sat <= 1'b1; else total <= sum[63:0];
      jj <= jj + 1'b1; mm <= '0; acc <= '0;
    end
    if (state == BK_EMIT && (!res_valid || res_ready)) begin
      res_comp <= 2'(cc);
      res_dist <= sat ? SAT64 : total;
      res_last <= (7'(cc) + 7'd1 == nc_r);
      cc <= cc + 1'b1; jj <= '0; mm <= '0; total <= '0; sat <= 1'b0;
    end
  end

  // The datapath must be empty when a column closes.
  a_drain: assert property (@(posedge clk) disable iff (rst)
    state == BK_COLUMN |-> !rd_v && !df_v && !prod_v) else $error("column closed early");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid) else $error("result dropped");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    state != BK_IDLE |-> !cmd_ready) else $error("accept while busy");
endmodule
`default_nettype wire

// ===== rtl/core/smd_front.sv =====
// Front end: accepts items, clamps configuration, classifies the item and
// pushes a command into a two-entry queue. Depends on smd_pkg.
`default_nettype none
module smd_front (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [3:0]  cfg_data,
  smd_in_if.sink           in_ch,
  output logic             q_valid,
  input  wire logic        q_ready,
  output logic [1:0]       q_action,
  output logic [1:0]       q_comp,
  output logic [2:0]       q_row,
  output logic [2:0]       q_col,
  output logic [31:0]      q_value,
  output logic             q_fire,
  output logic [6:0]       q_nd,
  output logic [6:0]       q_nc
);
  import smd_pkg::*;

  logic [3:0] dims_used;
  logic [2:0] components_used;
  logic [6:0] nd, nc;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      dims_used <= 4'd8;
      components_used <= 3'd4;
    end else if (cfg_we) begin
      if (32'(cfg_index) == CFG_DIMS) dims_used <= cfg_data;
      else components_used <= cfg_data[2:0];
    end
  end

  always_comb begin
    nd = (dims_used == 0) ? 7'd1 : (32'(dims_used) > MAX_DIMS) ? 7'(MAX_DIMS) : 7'(dims_used);
    nc = (components_used == 0) ? 7'd1 :
         (32'(components_used) > MAX_COMPONENTS) ? 7'(MAX_COMPONENTS) : 7'(components_used);
  end

  // Two-entry queue.
  localparam int QW = 2 + 2 + 3 + 3 + 32 + 1 + 7 + 7;
  logic [QW-1:0] qm [2];
  logic [1:0] cnt;
  logic rp, wp, push, pop;
  logic [QW-1:0] wd;
  assign in_ch.ready = (cnt != 2'd2);
  assign push = in_ch.valid && in_ch.ready && in_ch.action != ACT_NONE;
  assign pop = q_valid && q_ready;
  assign q_valid = (cnt != 2'd0);
  assign wd = {in_ch.action, in_ch.component, in_ch.row, in_ch.col, in_ch.value,
               (7'(in_ch.row) + 7'd1 == nd), nd, nc};
  assign {q_action, q_comp, q_row, q_col, q_value, q_fire, q_nd, q_nc} = qm[rp];

  always_ff @(posedge clk) begin
    if (push) qm[wp] <= wd;
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0; rp <= 1'b0; wp <= 1'b0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  a_cnt: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("queue count bad");
  a_full: assert property (@(posedge clk) disable iff (rst)
    cnt == 2'd2 && !pop |=> cnt == 2'd2) else $error("queue lost entry");
  a_empty: assert property (@(posedge clk) disable iff (rst)
    cnt == 2'd0 |-> !pop) else $error("pop from empty");
endmodule
`default_nettype wire

// ===== rtl/core/squared_mahalanobis_distance.sv =====
// Squared Mahalanobis distance engine, top level; depends on smd_pkg,
// smd_if, smd_front, smd_back and smd_ram.
// A load passes through the queue and is written to its store when the back end takes it. A point's last
// coordinate starts D*(D+1)/2 factor reads, a drain and close per column and an emit per component
// on one shared multiplier; a stalled result holds the back end in its emit state.
// Reset is synchronous; stores are undefined until written.
`default_nettype none
module squared_mahalanobis_distance (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [3:0]  cfg_data,
  smd_in_if.sink           in_ch,
  smd_out_if.source        out_ch
);
  import smd_pkg::*;

  logic q_valid, q_ready, q_fire;
  logic [1:0] q_action, q_comp;
  logic [2:0] q_row, q_col;
  logic [31:0] q_value;
  logic [6:0] q_nd, q_nc;

  smd_front u_front (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_ch), .q_valid(q_valid), .q_ready(q_ready), .q_action(q_action),
    .q_comp(q_comp), .q_row(q_row), .q_col(q_col), .q_value(q_value),
    .q_fire(q_fire), .q_nd(q_nd), .q_nc(q_nc));

  smd_back u_back (
    .clk(clk), .rst(rst), .cmd_valid(q_valid), .cmd_ready(q_ready),
    .cmd_action(q_action), .cmd_comp(q_comp), .cmd_row(q_row), .cmd_col(q_col),
    .cmd_value(q_value), .cmd_fire(q_fire), .cmd_nd(q_nd), .cmd_nc(q_nc),
    .res_valid(out_ch.valid), .res_ready(out_ch.ready), .res_comp(out_ch.comp_index),
    .res_dist(out_ch.distance), .res_last(out_ch.last_of_run));
endmodule
`default_nettype wire
